### sv/utf8sd_pkg.sv
// Shared constants and types for the UTF-8 stream decoder.
package utf8sd_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned CntWidth = 3;

  localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;

  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContCode = 8'h80;

  // Decoded work for one byte: n_rep replacement code points, then an
  // optional data code point.
  typedef struct packed {
    logic [CntWidth-1:0] n_rep;
    logic                has_data;
    logic [CpWidth-1:0]  cp;
    logic                eos;
  } job_t;

endpackage

### sv/utf8sd_if.sv
// Valid/ready channel interfaces for bytes in and code points out.
interface utf8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8sd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_run;
  logic        last_of_string;

  modport source (output valid, output code_point, output replaced, output last_of_run,
                  output last_of_string, input ready);
  modport sink (input valid, input code_point, input replaced, input last_of_run,
                input last_of_string, output ready);
endinterface

### sv/utf8sd_decode.sv
// Sequence state and per-byte decode into a result job.
module utf8sd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_string,
  output utf8sd_pkg::job_t  job
);
  import utf8sd_pkg::*;

  logic [CpWidth-1:0] partial_code;
  logic [1:0]         bytes_expected;
  logic [1:0]         bytes_seen;
  logic [CpWidth-1:0] partial_code_next;
  logic [1:0]         bytes_expected_next;
  logic [1:0]         bytes_seen_next;

  logic               pending;
  logic               is_cont;
  logic [2:0]         seen_inc;
  logic [CntWidth-1:0] n_rep;

  assign pending = (bytes_expected != 2'd0);
  assign is_cont = ((data_byte & ContMask) == ContCode);
  assign seen_inc = {1'b0, bytes_seen} + 3'd1;

  always_comb begin
    partial_code_next = partial_code;
    bytes_expected_next = bytes_expected;
    bytes_seen_next = bytes_seen;
    n_rep = '0;
    job.has_data = 1'b0;
    job.cp = {13'd0, data_byte};
    job.eos = end_of_string;

    if (pending && is_cont) begin
      // Append six payload bits; complete when all continuations are in.
      partial_code_next = {partial_code[CpWidth-7:0], data_byte[5:0]};
      if (seen_inc >= {1'b0, bytes_expected}) begin
        job.has_data = 1'b1;
        job.cp = {partial_code[CpWidth-7:0], data_byte[5:0]};
        partial_code_next = '0;
        bytes_expected_next = 2'd0;
        bytes_seen_next = 2'd0;
      end else begin
        bytes_seen_next = seen_inc[1:0];
      end
    end else begin
      if (pending) begin
        // Broken sequence: one replacement for the lead and each continuation.
        n_rep = seen_inc;
        partial_code_next = '0;
        bytes_expected_next = 2'd0;
        bytes_seen_next = 2'd0;
      end
      priority if (!data_byte[7]) begin
        job.has_data = 1'b1;
      end else if ((data_byte & Lead2Mask) == Lead2Code) begin
        partial_code_next = {16'd0, data_byte[4:0]};
        bytes_expected_next = 2'd1;
        bytes_seen_next = 2'd0;
      end else if ((data_byte & Lead3Mask) == Lead3Code) begin
        partial_code_next = {17'd0, data_byte[3:0]};
        bytes_expected_next = 2'd2;
        bytes_seen_next = 2'd0;
      end else if ((data_byte & Lead4Mask) == Lead4Code) begin
        partial_code_next = {18'd0, data_byte[2:0]};
        bytes_expected_next = 2'd3;
        bytes_seen_next = 2'd0;
      end else begin
        n_rep = n_rep + 3'd1;
      end
    end

    // Flush whatever is still pending at the end of the string.
    if (end_of_string && (bytes_expected_next != 2'd0)) begin
      n_rep = n_rep + {1'b0, bytes_seen_next} + 3'd1;
      partial_code_next = '0;
      bytes_expected_next = 2'd0;
      bytes_seen_next = 2'd0;
    end
    job.n_rep = n_rep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code <= '0;
      bytes_expected <= 2'd0;
      bytes_seen <= 2'd0;
    end else if (accept) begin
      partial_code <= partial_code_next;
      bytes_expected <= bytes_expected_next;
      bytes_seen <= bytes_seen_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (bytes_expected == 2'd0) |-> (bytes_seen == 2'd0 && partial_code == '0))
    else $error("idle decoder holds stale sequence state");

  a_seen_below_expected: assert property (@(posedge clk) disable iff (rst)
    (bytes_expected != 2'd0) |-> (bytes_seen < bytes_expected))
    else $error("continuation count reached expected without completing");

  a_burst_bound: assert property (@(posedge clk) disable iff (rst)
    accept |-> ({1'b0, job.n_rep} + {3'd0, job.has_data} <= 4'd4))
    else $error("one byte produced more than four results");

endmodule

### sv/utf8sd_emit.sv
// Result register that plays out the replacement and data code points of one byte.
module utf8sd_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  utf8sd_pkg::job_t   job,
  output logic               can_take,
  utf8sd_out_if.source       tx
);
  import utf8sd_pkg::*;

  logic [CntWidth-1:0] rem;
  logic [CntWidth-1:0] rep_left;
  logic [CpWidth-1:0]  cp;
  logic                eos;
  logic                take;

  assign tx.valid = (rem != '0);
  assign take = tx.valid && tx.ready;
  assign can_take = (rem == '0) || (take && rem == 3'd1);

  assign tx.replaced = (rep_left != '0);
  assign tx.code_point = (rep_left != '0) ? ReplacementCp : cp;
  assign tx.last_of_run = (rem == 3'd1);
  assign tx.last_of_string = (rem == 3'd1) && eos;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      rep_left <= '0;
    end else if (load) begin
      rem <= job.n_rep + {2'd0, job.has_data};
      rep_left <= job.n_rep;
    end else if (take) begin
      rem <= rem - 3'd1;
      if (rep_left != '0) begin
        rep_left <= rep_left - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp <= job.cp;
      eos <= job.eos;
    end
  end

  a_rep_within_rem: assert property (@(posedge clk) disable iff (rst)
    rep_left <= rem)
    else $error("more replacements pending than results left");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (take && !load && rem > 3'd1) |=> (rem == $past(rem) - 3'd1))
    else $error("burst counter did not advance on transfer");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    load |-> can_take)
    else $error("new job loaded over an unfinished burst");

endmodule

### sv/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: byte channel in, code point channel out.
// The first result of a byte is registered and appears on tx in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one code point and tx is ready.
// A byte that yields k code points (k up to 4) holds rx off while the result register
// plays them out; lead and continuation bytes that yield none do not hold rx off.
// Synchronous reset drops any pending sequence and any undelivered code points.
module utf8_stream_decoder (
  input  logic          clk,
  input  logic          rst,
  utf8sd_in_if.sink     rx,
  utf8sd_out_if.source  tx
);
  import utf8sd_pkg::*;

  job_t job;
  logic can_take;
  logic accept;

  assign rx.ready = can_take;
  assign accept = rx.valid && rx.ready;

  utf8sd_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (rx.data_byte),
    .end_of_string (rx.end_of_string),
    .job           (job)
  );

  utf8sd_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .job      (job),
    .can_take (can_take),
    .tx       (tx)
  );

endmodule

### dv/tb_top.sv
// Testbench for utf8_stream_decoder: byte stimulus, code point prediction and checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8sd_pkg::*;

  typedef struct packed {
    logic [CpWidth-1:0] cp;
    logic               replaced;
    logic               last_run;
    logic               last_str;
  } code_rec_t;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         drain;
  } byte_item_t;

  typedef enum int {GlyphAscii, GlyphTwo, GlyphThree, GlyphFour} glyph_e;
  typedef enum int {FaultNone, FaultStray, FaultBadLead, FaultCut} fault_e;

  localparam int LongHoldCycles = 80;
  localparam int LongHoldAfter  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  utf8sd_in_if  rx_if ();
  utf8sd_out_if tx_if ();

  utf8_stream_decoder DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    rx_if.valid = 1'b0;
    rx_if.data_byte = 8'h00;
    rx_if.end_of_string = 1'b0;
    tx_if.ready = 1'b0;
  end

  // Decoder state mirror
  logic [CpWidth-1:0] pend_code = '0;
  logic [1:0]         pend_need = '0;
  logic [1:0]         pend_seen = '0;

  code_rec_t  pending_codes [$];
  byte_item_t byte_q [$];

  int  total_bytes = 0;
  int  bytes_taken = 0;
  int  codes_checked = 0;
  int  repl_seen = 0;
  int  strings_ended = 0;
  int  errors = 0;
  bit  drain_next = 0;

  int  send_gap = 0;
  int  send_calm = 0;
  int  recv_gap = 0;
  int  recv_calm = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(8, 24);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 7);
    return $urandom_range(12, 35);
  endfunction

  task automatic add_code(input logic [CpWidth-1:0] cp, input logic rep);
    code_rec_t c;
    c.cp = cp;
    c.replaced = rep;
    c.last_run = 1'b0;
    c.last_str = 1'b0;
    pending_codes.insert(pending_codes.size(), c);
  endtask

  // Emit one replacement for the lead and one per buffered continuation.
  task automatic flush_seq();
    for (int k = 0; k <= int'(pend_seen); k++) add_code(ReplacementCp, 1'b1);
    pend_code = '0;
    pend_need = '0;
    pend_seen = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos);
    int        n_before;
    bit        used;
    code_rec_t tail;
    n_before = pending_codes.size();
    used = 0;
    if (pend_need != 0) begin
      if ((b & ContMask) == ContCode) begin
        pend_code = {pend_code[CpWidth-7:0], b[5:0]};
        pend_seen++;
        if (pend_seen >= pend_need) begin
          add_code(pend_code, 1'b0);
          pend_code = '0;
          pend_need = '0;
          pend_seen = '0;
        end
        used = 1;
      end else begin
        flush_seq();
      end
    end
    if (!used) begin
      if (!b[7]) begin
        add_code(CpWidth'(b), 1'b0);
      end else if ((b & Lead2Mask) == Lead2Code) begin
        pend_code = CpWidth'(b[4:0]);
        pend_need = 2'd1;
        pend_seen = '0;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        pend_code = CpWidth'(b[3:0]);
        pend_need = 2'd2;
        pend_seen = '0;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        pend_code = CpWidth'(b[2:0]);
        pend_need = 2'd3;
        pend_seen = '0;
      end else begin
        add_code(ReplacementCp, 1'b1);
      end
    end
    if (eos && pend_need != 0) flush_seq();
    // Tag the final result of this byte
    if (pending_codes.size() > n_before) begin
      tail = pending_codes[pending_codes.size() - 1];
      tail.last_run = 1'b1;
      tail.last_str = eos;
      pending_codes[pending_codes.size() - 1] = tail;
    end
  endtask

  task automatic put(input logic [7:0] b, input logic eos);
    byte_item_t it;
    it.b = b;
    it.eos = eos;
    it.drain = drain_next;
    drain_next = 0;
    byte_q.insert(byte_q.size(), it);
    total_bytes++;
  endtask

  // One string of well-formed characters, now and then damaged.
  task automatic gen_string();
    int         n_chars;
    int         nb;
    int         r;
    glyph_e     kind;
    fault_e     fault;
    logic [7:0] seq [4];
    byte_item_t tail;
    n_chars = $urandom_range(1, 6);
    for (int k = 0; k < n_chars; k++) begin
      r = $urandom_range(0, 99);
      kind = (r < 40) ? GlyphAscii : (r < 60) ? GlyphTwo : (r < 80) ? GlyphThree : GlyphFour;
      r = $urandom_range(0, 99);
      fault = (r < 84) ? FaultNone : (r < 89) ? FaultStray : (r < 94) ? FaultBadLead : FaultCut;
      for (int j = 1; j < 4; j++) seq[j] = {2'b10, 6'($urandom)};
      case (kind)
        GlyphAscii: begin
          seq[0] = {1'b0, 7'($urandom)};
          nb = 1;
        end
        GlyphTwo: begin
          seq[0] = {3'b110, 5'($urandom)};
          nb = 2;
        end
        GlyphThree: begin
          seq[0] = {4'b1110, 4'($urandom)};
          nb = 3;
        end
        default: begin
          seq[0] = {5'b11110, 3'($urandom)};
          nb = 4;
        end
      endcase
      if (fault == FaultStray) put({2'b10, 6'($urandom)}, 1'b0);
      if (fault == FaultBadLead) put(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
      if (fault == FaultCut && nb > 1) nb = $urandom_range(1, nb - 1);
      for (int j = 0; j < nb; j++) put(seq[j], 1'b0);
    end
    // Most strings carry an end mark; the rest run on into the next one
    if ($urandom_range(0, 9) < 8) begin
      tail = byte_q[byte_q.size() - 1];
      tail.eos = 1'b1;
      byte_q[byte_q.size() - 1] = tail;
    end
  endtask

  // Byte driver
  always @(posedge clk) begin
    byte_item_t cur;
    if (rst) begin
      rx_if.valid <= 1'b0;
      rx_if.data_byte <= 8'h00;
      rx_if.end_of_string <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        decode_byte(rx_if.data_byte, rx_if.end_of_string);
        bytes_taken++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          rx_if.valid <= 1'b0;
        end else if (byte_q.size() != 0 && !(byte_q[0].drain && pending_codes.size() != 0)) begin
          cur = byte_q.pop_front();
          rx_if.valid <= 1'b1;
          rx_if.data_byte <= cur.b;
          rx_if.end_of_string <= cur.eos;
          // keep offering while the receiver is held off
          send_gap = (hold_left > 0) ? 0 : pick_gap(send_calm);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Code point receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      tx_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      tx_if.ready <= 1'b0;
    end else if (!hold_done && codes_checked >= LongHoldAfter) begin
      hold_done = 1;
      hold_left = LongHoldCycles;
      tx_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      tx_if.ready <= 1'b0;
    end else begin
      tx_if.ready <= 1'b1;
      recv_gap = pick_gap(recv_calm);
    end
  end

  // Code point checker
  always @(posedge clk) begin
    code_rec_t got;
    code_rec_t want;
    if (!rst && tx_if.valid && tx_if.ready) begin
      got.cp = tx_if.code_point;
      got.replaced = tx_if.replaced;
      got.last_run = tx_if.last_of_run;
      got.last_str = tx_if.last_of_string;
      codes_checked++;
      if (got.replaced) repl_seen++;
      if (got.last_str) strings_ended++;
      if (pending_codes.size() == 0) begin
        $error("unexpected code point %06h with nothing pending", got.cp);
        errors++;
      end else begin
        want = pending_codes.pop_front();
        if (got.cp !== want.cp) begin
          $error("code_point: expected %06h, got %06h", want.cp, got.cp);
          errors++;
        end
        if (got.replaced !== want.replaced) begin
          $error("replaced: expected %0b, got %0b", want.replaced, got.replaced);
          errors++;
        end
        if (got.last_run !== want.last_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_run, got.last_run);
          errors++;
        end
        if (got.last_str !== want.last_str) begin
          $error("last_of_string: expected %0b, got %0b", want.last_str, got.last_str);
          errors++;
        end
      end
    end
  end

  initial begin
    int rand_start;
    // ASCII extremes
    put(8'h00, 1'b0);
    put(8'h7F, 1'b1);
    // overlong zero and top of the two-byte range
    put(8'hC0, 1'b0); put(8'h80, 1'b0);
    put(8'hDF, 1'b0); put(8'hBF, 1'b0);
    // surrogate passes through
    put(8'hED, 1'b0); put(8'hA0, 1'b0); put(8'h80, 1'b0);
    // largest four-byte value
    put(8'hF7, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b0);
    // stray continuation, bad leads
    put(8'h80, 1'b0);
    put(8'hF8, 1'b0);
    put(8'hFF, 1'b0);
    // sequence broken by ASCII after two continuations
    put(8'hF0, 1'b0); put(8'h90, 1'b0); put(8'h80, 1'b0); put(8'h41, 1'b0);
    // cut short by the end mark
    put(8'hE1, 1'b0); put(8'h80, 1'b1);
    // pending lead waits, then a bad lead breaks it at string end
    put(8'hC3, 1'b0);
    put(8'hFE, 1'b1);

    // Pause until the directed part has fully drained, and once more midway
    drain_next = 1;
    rand_start = total_bytes;
    while (total_bytes - rand_start < 43) gen_string();
    drain_next = 1;
    while (total_bytes - rand_start < 86) gen_string();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tb_top: %0d bytes in, %0d code points checked", bytes_taken, codes_checked);
    $display("tb_top: %0d replacements, %0d end-of-string marks", repl_seen, strings_ended);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
